FILE: rtl/gcol_pkg.sv
package gcol_pkg;

    localparam int IDX_W            = 6;
    localparam int COLOR_W          = 6;
    localparam int ROW_W            = 64;
    localparam int VCOUNT_W         = 7;
    localparam int MAX_VERTICES_DEF = 64;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 7'd64;

    // register index codes (byte address / 4)
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_LOAD,
        ST_SCAN,
        ST_FIT,
        ST_EMIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] last_idx;
    } t_start;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_adj_rd;

    typedef struct packed {
        logic               last;
        logic [COLOR_W-1:0] highest;
        logic [COLOR_W-1:0] color;
        logic [IDX_W-1:0]   vertex;
    } t_result;

endpackage

FILE: rtl/greedy_graph_coloring_core.sv
// First-fit graph coloring: rows load at one word per cycle (ready while idle).
// A word marked tlast starts coloring; each vertex goes through a row read,
// a neighbor scan one bit per cycle through the color store and a
// lowest-free search one color per cycle, then waits out any output stall;
// the input is not ready until the whole pass is done.
// Reset (sync, active low) clears control and sets vertex_count to 64; rows are not cleared.
module greedy_graph_coloring_core
    import gcol_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // [5:0] row_index, [69:6] row_bits, [71:70] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tlast,
    output logic                  o_s_tready,
    // [5:0] vertex, [11:6] color, [17:12] highest_color, [23:18] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tvalid,
    output logic                  o_m_tlast,
    input  logic                  i_m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [VCOUNT_W-1:0] MAXV = VCOUNT_W'(MAX_VERTICES);

    logic [VCOUNT_W-1:0] r_vcount;
    logic                in_acc;
    logic [IDX_W-1:0]    row_index;
    logic                row_in_range;
    logic [IDX_W-1:0]    last_idx;
    logic                eng_idle;
    t_start              start;
    t_adj_rd             adj_rd;
    logic [ROW_W-1:0]    adj_data;
    t_result             res;
    logic                res_valid;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_VERTEX_COUNT) begin
            r_vcount <= pwdata[VCOUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_VERTEX_COUNT) begin
            prdata = APB_DATA_W'(r_vcount);
        end
    end

    // vertex count saturates to 1..MAX_VERTICES
    always_comb begin
        if (r_vcount == '0) begin
            last_idx = '0;
        end else if (r_vcount > MAXV) begin
            last_idx = IDX_W'(MAXV - 1'b1);
        end else begin
            last_idx = IDX_W'(r_vcount - 1'b1);
        end
    end

    assign o_s_tready   = eng_idle;
    assign in_acc       = i_s_tvalid && o_s_tready;
    assign row_index    = i_s_tdata[IDX_W-1:0];
    assign row_in_range = ({1'b0, row_index} < MAXV);

    assign start.start    = in_acc && i_s_tlast;
    assign start.last_idx = last_idx;

    gcol_adj_mem #(
        .DEPTH (MAX_VERTICES)
    ) u_adj_mem (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && row_in_range),
        .i_wr_addr (row_index),
        .i_wr_data (i_s_tdata[IDX_W+ROW_W-1:IDX_W]),
        .i_rd      (adj_rd),
        .o_rd_data (adj_data)
    );

    gcol_engine #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_idle      (eng_idle),
        .o_adj_rd    (adj_rd),
        .i_adj_data  (adj_data),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tvalid = res_valid;
    assign o_m_tlast  = res.last;
    assign o_m_tdata  = {6'd0, res.highest, res.color, res.vertex};

endmodule

FILE: rtl/gcol_adj_mem.sv
module gcol_adj_mem
    import gcol_pkg::*;
#(
    parameter int DEPTH = MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [ROW_W-1:0] i_wr_data,
    input  t_adj_rd          i_rd,
    output logic [ROW_W-1:0] o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr[AW-1:0]] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/gcol_engine.sv
module gcol_engine
    import gcol_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_start           i_start,
    output logic             o_idle,
    output t_adj_rd          o_adj_rd,
    input  logic [ROW_W-1:0] i_adj_data,
    output t_result          o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready
);

    localparam int VW = $clog2(MAX_VERTICES);

    t_state                  r_state, n_state;
    logic [VW-1:0]           r_i;
    logic [VW-1:0]           r_j;
    logic [VW-1:0]           r_last_idx;
    logic [VW-1:0]           r_high;
    logic [MAX_VERTICES-1:0] r_nb;
    logic [MAX_VERTICES-1:0] r_used;
    logic                    r_pend;
    t_result                 r_res;
    logic                    r_res_valid;

    logic [VW-1:0]           r_colors [MAX_VERTICES];
    logic [VW-1:0]           r_col_rd;

    logic [MAX_VERTICES-1:0] earlier_mask;
    logic [MAX_VERTICES-1:0] col_onehot;
    logic                    scan_done;
    logic                    col_rd_en;
    logic                    col_wr_en;
    logic [VW-1:0]           new_high;

    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            earlier_mask[k] = (k < int'(r_i));
            col_onehot[k]   = (r_col_rd == VW'(k));
        end
    end

    assign scan_done = (r_j == r_i);
    assign new_high  = (r_j > r_high) ? r_j : r_high;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start.start) n_state = ST_ROW;
            ST_ROW:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_SCAN;
            ST_SCAN: if (scan_done) n_state = ST_FIT;
            ST_FIT:  if (!r_used[r_j]) n_state = ST_EMIT;
            ST_EMIT: n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = (r_i == r_last_idx) ? ST_IDLE : ST_ROW;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle        = 1'b0;
        o_adj_rd.en   = 1'b0;
        o_adj_rd.addr = IDX_W'(r_i);
        col_rd_en     = 1'b0;
        col_wr_en     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_idle = 1'b1;
            ST_ROW:  o_adj_rd.en = 1'b1;
            ST_SCAN: col_rd_en = !scan_done;
            ST_EMIT: col_wr_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // vertex color store
    always_ff @(posedge i_clk) begin
        if (col_wr_en) begin
            r_colors[r_i] <= r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (col_rd_en) begin
            r_col_rd <= r_colors[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: r_pend <= 1'b0;
                ST_SCAN: r_pend <= !scan_done && r_nb[r_j];
                default: r_pend <= 1'b0;
            endcase
            if (r_state == ST_EMIT) begin
                r_res_valid <= 1'b1;
            end else if (r_state == ST_OUT && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // the color read issued last cycle lands now
        if (r_pend) begin
            r_used <= r_used | col_onehot;
        end
        case (r_state)
            ST_IDLE: begin
                r_i        <= '0;
                r_high     <= '0;
                r_last_idx <= i_start.last_idx[VW-1:0];
            end
            ST_LOAD: begin
                r_nb   <= i_adj_data[MAX_VERTICES-1:0] & earlier_mask;
                r_used <= '0;
                r_j    <= '0;
            end
            ST_SCAN: begin
                r_j <= scan_done ? '0 : r_j + 1'b1;
            end
            ST_FIT: begin
                if (r_used[r_j]) begin
                    r_j <= r_j + 1'b1;
                end
            end
            ST_EMIT: begin
                r_high         <= new_high;
                r_res.vertex   <= IDX_W'(r_i);
                r_res.color    <= COLOR_W'(r_j);
                r_res.highest  <= COLOR_W'(new_high);
                r_res.last     <= (r_i == r_last_idx);
            end
            ST_OUT: begin
                if (i_res_ready && r_i != r_last_idx) begin
                    r_i <= r_i + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

`ifndef ASSERT_OFF
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_j <= r_i)
        else $error("neighbor scan ran past current vertex");

    a_color_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> !r_used[r_j])
        else $error("assigned color is held by a neighbor");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start.start |-> r_state == ST_IDLE)
        else $error("start while coloring");

    a_high_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> r_res.highest >= r_res.color)
        else $error("highest color below reported color");

    a_vertex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_i <= r_last_idx)
        else $error("vertex beyond count");
`endif

endmodule

FILE: bench/testbench.sv
module testbench;
    import gcol_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_ROWS    = 20;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    // [5:0] row_index, [69:6] row_bits, [71:70] zero
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  i_s_tlast  = 1'b0;
    logic                  o_s_tready;
    // [5:0] vertex, [11:6] color, [17:12] highest_color, [23:18] zero
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tvalid;
    logic                  o_m_tlast;
    logic                  i_m_tready = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    greedy_graph_coloring_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tlast  (o_m_tlast),
        .i_m_tready (i_m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [ROW_W-1:0]            adj_rows   [MAX_VERTICES_DEF];
    logic [COLOR_W-1:0]          vtx_colors [MAX_VERTICES_DEF];
    logic [VCOUNT_W-1:0]         vcount_reg = VCOUNT_RST;
    logic [MAX_VERTICES_DEF-1:0] row_written = '0;
    t_result                     color_q[$];

    int err_count     = 0;
    int rows_sent     = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // first-fit pass over vertices 0..n-1, queues one expected word per vertex
    function automatic void predict_coloring();
        int                 n, i, j;
        logic [63:0]        used;
        logic [COLOR_W-1:0] c, top;
        t_result            r;
        n = int'(vcount_reg);
        if (n < 1) n = 1;
        if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
        top = '0;
        for (i = 0; i < n; i++) begin
            used = '0;
            for (j = 0; j < i; j++)
                if (adj_rows[i][j]) used[vtx_colors[j]] = 1'b1;
            c = '0;
            while (c < 63 && used[c]) c++;
            vtx_colors[i] = c;
            if (c > top) top = c;
            r.vertex  = IDX_W'(i);
            r.color   = c;
            r.highest = top;
            r.last    = (i == n - 1);
            color_q.push_back(r);
        end
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return a & b & {$urandom, $urandom};
            1: return a & b;
            2: return a;
            default: return a | b;
        endcase
    endfunction

    task automatic set_phase(input int p);
        case (p % 4)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_idle_pct = 69;
                stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 69;
            end
            default: begin
                send_idle_pct = 22;
                stall_pct = 22;
            end
        endcase
    endtask

    // valid stays high after a word is taken so back-to-back words need no re-raise
    task automatic send_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                            input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tdata  <= {2'b00, bits, idx};
        i_s_tlast  <= last;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        adj_rows[idx]    = bits;
        row_written[idx] = 1'b1;
        rows_sent++;
        if (last) predict_coloring();
    endtask

    // register writes only once the block has drained
    task automatic set_vertex_count(input int value);
        i_s_tvalid <= 1'b0;
        while (color_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_VERTEX_COUNT));
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        vcount_reg = VCOUNT_W'(value);
    endtask

    task automatic test_directed();
        set_phase(0);
        // single vertex: self-loop and later bits ignored
        set_vertex_count(1);
        send_row(0, '1, 1'b1);
        // count of zero behaves as one
        set_vertex_count(0);
        send_row(0, '0, 1'b1);
        set_vertex_count(5);
        send_row(0, '1, 1'b0);
        send_row(1, 64'h1, 1'b0);
        send_row(2, 64'h17, 1'b0);          // self-loop and a later neighbor
        send_row(3, 64'h2, 1'b0);
        send_row(4, 64'h8, 1'b0);           // edge only seen from row 4
        // last mark on a row outside the active count still starts a pass
        send_row(63, '0, 1'b1);
        // stored rows persist, only row 2 changes
        send_row(2, 64'h5, 1'b1);
    endtask

    task automatic test_complete_graph();
        int r;
        set_phase(1);
        set_vertex_count(64);
        for (r = 0; r < 64; r++)
            send_row(IDX_W'(r), '1, r == 63);
        // above the vertex limit saturates to 64
        set_vertex_count(127);
        send_row(10, '0, 1'b1);
    endtask

    task automatic test_random_graphs();
        int start, run, count, n, r;
        start = rows_sent;
        run = 2;
        while (rows_sent - start < RANDOM_ROWS) begin
            set_phase(run++);
            case ($urandom_range(15))
                0: count = 0;
                1: count = 1;
                2: count = 64;
                3: count = 127;
                4: count = $urandom_range(65, 126);
                default: count = $urandom_range(2, 12);
            endcase
            set_vertex_count(count);
            n = (count < 1) ? 1 : ((count > 64) ? 64 : count);
            for (r = 0; r < n; r++)
                if (!row_written[r] || $urandom_range(n - 1) < 4)
                    send_row(IDX_W'(r), random_row(), 1'b0);
            repeat ($urandom_range(2))
                send_row(IDX_W'($urandom_range(63)), random_row(), 1'b0);
            // now and then a run ends without a last word
            if ($urandom_range(7) != 0)
                send_row(IDX_W'($urandom_range(63)), random_row(), 1'b1);
        end
    endtask

    task automatic test_output_hold();
        int r;
        set_phase(0);
        set_vertex_count(12);
        hold_token++;
        for (r = 0; r < 12; r++)
            send_row(IDX_W'(r), random_row(), r == 11);
        // these wait behind the stalled pass
        repeat (6) send_row(IDX_W'($urandom_range(63)), random_row(), 1'b0);
        send_row(IDX_W'($urandom_range(11)), random_row(), 1'b1);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.vertex  = o_m_tdata[5:0];
            got.color   = o_m_tdata[11:6];
            got.highest = o_m_tdata[17:12];
            got.last    = o_m_tlast;
            if (color_q.size() == 0) begin
                report($sformatf("unexpected word: vertex %0d color %0d",
                                 got.vertex, got.color));
            end else begin
                want = color_q.pop_front();
                if (got.vertex != want.vertex || got.color != want.color ||
                    got.highest != want.highest || got.last != want.last)
                    report($sformatf("vertex %0d/%0d color %0d/%0d highest %0d/%0d last %0d/%0d",
                                     got.vertex, want.vertex, got.color, want.color,
                                     got.highest, want.highest, got.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("greedy_graph_coloring_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int i;
        for (i = 0; i < MAX_VERTICES_DEF; i++) begin
            adj_rows[i]   = '0;
            vtx_colors[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_complete_graph();
        test_random_graphs();
        test_output_hold();
        i_s_tvalid <= 1'b0;
        while (color_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("greedy_graph_coloring_core: match");
        else
            $display("greedy_graph_coloring_core: mismatch");
        $finish;
    end

endmodule
